// File: sv/sbt_pkg.sv
// Shared types and constants for the sorted breakpoint table.
// Used by sorted_breakpoint_table; no dependencies.
package sbt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SET_TEMP = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        which_cpu;
    logic [15:0] bp_address;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] entry_count;
  } rsp_t;

endpackage

// File: sv/sbt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sbt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sorted_breakpoint_table.sv
// Two breakpoint tables (central and peripheral processor) kept in one RAM.
// Depends on sbt_pkg and sbt_ram.
//
// A request is taken when start is high and busy is low. It carries a command
// (add, remove, set temporary, query), the table select and an address. Each
// request gives exactly one result: done is high for one cycle with ok and the
// entry count of the selected table after the command. The receiver cannot
// stall; done always falls in a cycle where busy is already low.
// Both tables share one RAM with a registered read, and every command walks it
// one entry per cycle. A query or a rejected add or remove ends after one scan
// of the selected table; a remove adds a move pass that closes the gap, and an
// add a move pass that opens one and a place step. Set temporary first scans
// for a held previous temporary and drops it if found, then scans and may append.
// One request is in flight at a time; the next one can be taken at the edge
// that ends the done cycle.
// Reset clears the entry counts and the temporary registers. RAM contents are
// never used above the count of their table, so no clearing pass is needed
// and the block takes requests right after reset.
module sorted_breakpoint_table
  #(
  parameter int unsigned MAX_ENTRIES = sbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sbt_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output sbt_pkg::rsp_t result
);

  import sbt_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RAM_DEPTH = 2 * (1 << IW);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ADD_LIMIT = CW'(MAX_ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOVE, S_PLACE} state_t;

  state_t        state;
  cmd_t          op;
  logic          sel;
  logic          main_stage;
  logic [15:0]   addr;
  logic [15:0]   target;
  logic [CW-1:0] cpu_used;
  logic [CW-1:0] ppu_used;
  logic [15:0]   cpu_temp;
  logic [15:0]   ppu_temp;
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [IW-1:0] cmp_idx;
  logic          found;
  logic [IW-1:0] match_idx;
  logic          gt_found;
  logic [IW-1:0] gt_idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] mv_idx;
  logic [CW-1:0] mv_cnt;
  logic          mv_up;
  logic [IW-1:0] pend_dst;

  logic [CW-1:0] n;
  logic [15:0]   temp_in;
  logic [CW-1:0] ins_pos;
  logic [CW-1:0] mv_nbr;
  logic [CW-1:0] mv_step;
  logic          we;
  logic [IW:0]   waddr;
  logic [15:0]   wdata;
  logic [IW:0]   raddr;
  logic [15:0]   rdata;

  assign n       = sel ? cpu_used : ppu_used;
  assign temp_in = request.which_cpu ? cpu_temp : ppu_temp;
  assign ins_pos = gt_found ? CW'(gt_idx) : n;
  assign mv_nbr  = mv_up ? mv_idx + 1'b1 : mv_idx - 1'b1;
  assign mv_step = mv_up ? mv_idx - 1'b1 : mv_idx + 1'b1;
  assign busy    = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = {sel, pend_dst};
    wdata = rdata;
    raddr = {sel, rd_idx[IW-1:0]};
    unique case (state)
      S_MOVE: begin
        we    = pend;
        raddr = {sel, mv_idx[IW-1:0]};
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = {sel, pos[IW-1:0]};
        wdata = addr;
      end
      S_IDLE, S_SCAN: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sbt_ram #(
    .WIDTH(16),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      cpu_used <= '0;
      ppu_used <= '0;
      cpu_temp <= EMPTY_MARK;
      ppu_temp <= EMPTY_MARK;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op       <= request.cmd;
            sel      <= request.which_cpu;
            addr     <= request.bp_address;
            rd_idx   <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            gt_found <= 1'b0;
            state    <= S_SCAN;
            if (request.cmd == CMD_SET_TEMP && temp_in != EMPTY_MARK) begin
              target     <= temp_in;
              main_stage <= 1'b0;
            end else begin
              target     <= request.bp_address;
              main_stage <= 1'b1;
            end
          end
        end

        S_SCAN: begin
          if (pend) begin
            if (!found && rdata == target) begin
              found     <= 1'b1;
              match_idx <= cmp_idx;
            end
            if (!gt_found && rdata > target) begin
              gt_found <= 1'b1;
              gt_idx   <= cmp_idx;
            end
          end
          if (rd_idx < n) begin
            cmp_idx <= rd_idx[IW-1:0];
            rd_idx  <= rd_idx + 1'b1;
            pend    <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              unique case (op)
                CMD_ADD: begin
                  if (addr == EMPTY_MARK || n >= ADD_LIMIT || found) begin
                    result.ok          <= 1'b0;
                    result.entry_count <= 5'(n);
                    done               <= 1'b1;
                    state              <= S_IDLE;
                  end else begin
                    pos    <= ins_pos;
                    mv_idx <= n - 1'b1;
                    mv_cnt <= n - ins_pos;
                    mv_up  <= 1'b1;
                    state  <= S_MOVE;
                  end
                end
                CMD_REMOVE: begin
                  if (!found) begin
                    result.ok          <= 1'b0;
                    result.entry_count <= 5'(n);
                    done               <= 1'b1;
                    state              <= S_IDLE;
                  end else begin
                    mv_idx <= CW'(match_idx) + 1'b1;
                    mv_cnt <= n - 1'b1 - CW'(match_idx);
                    mv_up  <= 1'b0;
                    state  <= S_MOVE;
                  end
                end
                CMD_QUERY: begin
                  result.ok          <= found;
                  result.entry_count <= 5'(n);
                  done               <= 1'b1;
                  state              <= S_IDLE;
                end
                CMD_SET_TEMP: begin
                  if (!main_stage) begin
                    if (found) begin
                      mv_idx <= CW'(match_idx) + 1'b1;
                      mv_cnt <= n - 1'b1 - CW'(match_idx);
                      mv_up  <= 1'b0;
                      state  <= S_MOVE;
                    end else begin
                      target     <= addr;
                      main_stage <= 1'b1;
                      rd_idx     <= '0;
                      found      <= 1'b0;
                      gt_found   <= 1'b0;
                    end
                  end else begin
                    if (sel) begin
                      cpu_temp <= EMPTY_MARK;
                    end else begin
                      ppu_temp <= EMPTY_MARK;
                    end
                    if (addr == EMPTY_MARK) begin
                      result.ok          <= 1'b1;
                      result.entry_count <= 5'(n);
                      done               <= 1'b1;
                      state              <= S_IDLE;
                    end else if (found || n >= FULL_COUNT) begin
                      result.ok          <= 1'b0;
                      result.entry_count <= 5'(n);
                      done               <= 1'b1;
                      state              <= S_IDLE;
                    end else begin
                      pos   <= n;
                      state <= S_PLACE;
                    end
                  end
                end
                default: begin
                  state <= S_IDLE;
                end
              endcase
            end
          end
        end

        S_MOVE: begin
          if (mv_cnt != '0) begin
            pend     <= 1'b1;
            pend_dst <= mv_nbr[IW-1:0];
            mv_idx   <= mv_step;
            mv_cnt   <= mv_cnt - 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (mv_up) begin
                state <= S_PLACE;
              end else begin
                if (sel) begin
                  cpu_used <= n - 1'b1;
                end else begin
                  ppu_used <= n - 1'b1;
                end
                if (op == CMD_REMOVE) begin
                  result.ok          <= 1'b1;
                  result.entry_count <= 5'(n - 1'b1);
                  done               <= 1'b1;
                  state              <= S_IDLE;
                end else begin
                  target     <= addr;
                  main_stage <= 1'b1;
                  rd_idx     <= '0;
                  found      <= 1'b0;
                  gt_found   <= 1'b0;
                  state      <= S_SCAN;
                end
              end
            end
          end
        end

        S_PLACE: begin
          if (sel) begin
            cpu_used <= n + 1'b1;
          end else begin
            ppu_used <= n + 1'b1;
          end
          if (op == CMD_SET_TEMP) begin
            if (sel) begin
              cpu_temp <= addr;
            end else begin
              ppu_temp <= addr;
            end
          end
          result.ok          <= 1'b1;
          result.entry_count <= 5'(n + 1'b1);
          done               <= 1'b1;
          state              <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cpu_used <= FULL_COUNT) && (ppu_used <= FULL_COUNT))
    else $error("entry count above table size");

endmodule
